### hw/rtl/fage_pkg.sv
package fage_pkg;
    localparam int CFG_W = 3;
    localparam logic [2:0] REG_LEVELS = 3'd0;
    localparam logic [2:0] REG_COV1   = 3'd1;
    localparam logic [2:0] REG_COV2   = 3'd2;
    localparam logic [2:0] REG_COV3   = 3'd3;
    localparam logic [2:0] REG_COVL   = 3'd4;
    localparam logic [1:0] REQ_RULE   = 2'd0;
    localparam logic [1:0] REQ_LEAF   = 2'd1;
    localparam logic [1:0] REQ_EXPAND = 2'd2;
    localparam int RESULT_CAP = 64;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_STEP  = 6'b000010,
        S_RWAIT = 6'b000100,
        S_LEAF  = 6'b001000,
        S_LWAIT = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    function automatic logic [2:0] clamp_cov(input logic [2:0] c, input int mx);
        if (c == 3'd0) return 3'd1;
        if (int'(c) > mx) return 3'(mx);
        return c;
    endfunction
endpackage

### hw/rtl/fixed_arity_grammar_expander_top.sv
// Channel   | Direction | Ports
// request   | in        | i_start, o_busy, i_req_type, i_table_level, i_entry_index,
//           |           | i_entry_value, i_start_symbol
// result    | out       | o_valid, o_leaf_bytes, o_byte_count, o_last_of_run
// config    | in        | i_cfg_we, i_cfg_index, i_cfg_wdata
//
// A write request is written into its memory while the block is idle. An expand
// request walks the rule memory one entry per table read: issue the read, decode
// the registered data, climb out of a finished rule, read the leaf memory for
// each entry of a leaf rule, and close the run. A run stops at the 64-result cap.
// Reset is synchronous and holds busy high; the memories are not cleared. Each
// result is strobed for one cycle; the receiver cannot stall.
module fixed_arity_grammar_expander_top #(
    parameter int RULES_PER_LEVEL = 4096,
    parameter int MAX_COVER = 4,
    parameter int MAX_LEVELS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [1:0]             i_req_type,
    input  logic [1:0]             i_table_level,
    input  logic [13:0]            i_entry_index,
    input  logic [12:0]            i_entry_value,
    input  logic [12:0]            i_start_symbol,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [fage_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                   o_valid,
    output logic [31:0]            o_leaf_bytes,
    output logic [2:0]             o_byte_count,
    output logic                   o_last_of_run
);
    import fage_pkg::*;

    localparam int DEPTH = RULES_PER_LEVEL * MAX_COVER;
    localparam int AW = $clog2(DEPTH);
    localparam int ML = (MAX_LEVELS > 4) ? 4 : MAX_LEVELS;
    localparam int DW = (ML > 1) ? $clog2(ML) : 1;

    // rule memory holds three internal levels back to back
    logic [12:0] rule_mem [3*DEPTH];
    logic [7:0]  leaf_mem [DEPTH];
    logic [12:0] r_rule_q;
    logic [7:0]  r_leaf_q;

    logic [2:0] r_levels, r_cov1, r_cov2, r_cov3, r_covl;
    t_state r_state;
    logic [12:0] r_wsym [4];
    logic [2:0]  r_wpos [4];
    logic [DW-1:0] r_d;
    logic [2:0]  r_eff;
    logic [6:0]  r_nout;
    logic [12:0] r_leafsym;
    logic [2:0]  r_lj;
    logic [31:0] r_pack;
    logic [2:0]  r_cnt;
    logic        r_out_pend;
    logic [31:0] r_pend_bytes;
    logic [2:0]  r_pend_cnt;

    logic [2:0] eff_lv;
    always_comb begin
        eff_lv = (r_levels == 3'd0) ? 3'd1 : r_levels;
        if (int'(eff_lv) > ML) eff_lv = 3'(ML);
    end

    logic [2:0] cur_cov, leaf_cov;
    always_comb begin
        case (r_d)
            DW'(0):  cur_cov = clamp_cov(r_cov1, MAX_COVER);
            DW'(1):  cur_cov = clamp_cov(r_cov2, MAX_COVER);
            default: cur_cov = clamp_cov(r_cov3, MAX_COVER);
        endcase
        leaf_cov = clamp_cov(r_covl, MAX_COVER);
    end

    // address of the current walk entry; 32 bits covers every index
    logic [31:0] rule_idx, leaf_idx;
    logic        rule_oob, leaf_oob;
    logic [AW+1:0] rule_addr;
    always_comb begin
        rule_idx  = (32'(r_wsym[r_d]) - 32'd1) * 32'(cur_cov) + 32'(r_wpos[r_d]);
        rule_oob  = rule_idx >= 32'(DEPTH);
        rule_addr = (AW+2)'(32'(r_d) * 32'(DEPTH) + rule_idx);
        leaf_idx  = (32'(r_leafsym) - 32'd1) * 32'(leaf_cov) + 32'(r_lj);
        leaf_oob  = leaf_idx >= 32'(DEPTH);
    end

    logic [31:0] pk_out;
    logic [2:0]  pk_cnt;
    fage_leaf_packer u_pack (
        .i_byte  (r_leaf_q),
        .i_packed(r_pack),
        .i_count (r_cnt),
        .o_packed(pk_out),
        .o_count (pk_cnt)
    );

    logic accept;
    assign accept = i_start && !o_busy;
    assign o_busy = !i_rst_n || (r_state != S_IDLE);

    // memory writes and registered reads
    logic rule_we, leaf_we;
    logic [AW+1:0] rule_waddr;
    assign rule_we = accept && i_req_type == REQ_RULE && i_table_level != 2'd0
                     && 32'(i_entry_index) < 32'(DEPTH);
    assign rule_waddr = (AW+2)'((32'(i_table_level) - 32'd1) * 32'(DEPTH)
                     + 32'(i_entry_index));
    assign leaf_we = accept && i_req_type == REQ_LEAF && 32'(i_entry_index) < 32'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (rule_we) rule_mem[rule_waddr] <= i_entry_value;
        if (leaf_we) leaf_mem[AW'(i_entry_index)] <= i_entry_value[7:0];
        r_rule_q <= rule_oob ? 13'd0 : rule_mem[rule_addr];
        r_leaf_q <= leaf_oob ? 8'd0 : leaf_mem[AW'(leaf_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= 3'd1; r_cov1 <= 3'd2; r_cov2 <= 3'd2;
            r_cov3 <= 3'd2; r_covl <= 3'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LEVELS: r_levels <= i_cfg_wdata;
                REG_COV1:   r_cov1 <= i_cfg_wdata;
                REG_COV2:   r_cov2 <= i_cfg_wdata;
                REG_COV3:   r_cov3 <= i_cfg_wdata;
                REG_COVL:   r_covl <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // one result is held back so the final one can carry the last mark
    logic emit;
    logic [31:0] emit_bytes;
    logic [2:0]  emit_cnt;
    assign emit = (r_state == S_LWAIT) && (r_lj + 3'd1 >= leaf_cov);
    assign emit_bytes = pk_out;
    assign emit_cnt = pk_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_pend <= 1'b0;
            o_valid <= 1'b0;
            r_d <= '0;
            r_nout <= '0;
            for (int k = 0; k < 4; k++) begin
                r_wsym[k] <= '0;
                r_wpos[k] <= '0;
            end
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_req_type == REQ_EXPAND && i_start_symbol != 13'd0) begin
                        r_eff <= eff_lv;
                        r_nout <= '0;
                        r_out_pend <= 1'b0;
                        if (eff_lv == 3'd1) begin
                            r_leafsym <= i_start_symbol;
                            r_lj <= '0; r_pack <= '0; r_cnt <= '0;
                            r_state <= S_LEAF;
                        end else begin
                            r_d <= '0;
                            r_wsym[0] <= i_start_symbol;
                            r_wpos[0] <= '0;
                            r_state <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    if (r_nout == 7'(RESULT_CAP)) begin
                        r_state <= S_DONE;
                    end else if (r_wpos[r_d] >= cur_cov) begin
                        if (r_d == '0) r_state <= S_DONE;
                        else r_d <= r_d - DW'(1);
                    end else begin
                        r_state <= S_RWAIT;
                    end
                end
                S_RWAIT: begin
                    // read data now valid in r_rule_q
                    r_wpos[r_d] <= r_wpos[r_d] + 3'd1;
                    if (r_rule_q != 13'd0 && 3'(r_d) + 3'd2 == r_eff) begin
                        r_leafsym <= r_rule_q;
                        r_lj <= '0; r_pack <= '0; r_cnt <= '0;
                        r_state <= S_LEAF;
                    end else begin
                        r_state <= S_STEP;
                        if (r_rule_q != 13'd0) begin
                            r_d <= r_d + DW'(1);
                            r_wsym[r_d + DW'(1)] <= r_rule_q;
                            r_wpos[r_d + DW'(1)] <= '0;
                        end
                    end
                end
                S_LEAF: r_state <= S_LWAIT;
                S_LWAIT: begin
                    r_pack <= pk_out;
                    r_cnt <= pk_cnt;
                    if (emit) begin
                        r_nout <= r_nout + 7'd1;
                        r_state <= (r_eff == 3'd1) ? S_DONE : S_STEP;
                    end else begin
                        r_lj <= r_lj + 3'd1;
                        r_state <= S_LEAF;
                    end
                end
                S_DONE: begin
                    if (r_out_pend) begin
                        o_valid <= 1'b1;
                        o_leaf_bytes <= r_pend_bytes;
                        o_byte_count <= r_pend_cnt;
                        o_last_of_run <= 1'b1;
                    end
                    r_out_pend <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (emit) begin
                if (r_out_pend) begin
                    o_valid <= 1'b1;
                    o_leaf_bytes <= r_pend_bytes;
                    o_byte_count <= r_pend_cnt;
                    o_last_of_run <= 1'b0;
                end
                r_out_pend <= 1'b1;
                r_pend_bytes <= emit_bytes;
                r_pend_cnt <= emit_cnt;
            end
        end
    end
endmodule

### hw/rtl/fage_leaf_packer.sv
module fage_leaf_packer (
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_packed,
    input  logic [2:0]  i_count,
    output logic [31:0] o_packed,
    output logic [2:0]  o_count
);
    // append one byte if nonzero and room remains
    always_comb begin
        o_packed = i_packed;
        o_count  = i_count;
        if (i_byte != 8'd0 && i_count < 3'd4) begin
            o_packed = i_packed | ({24'd0, i_byte} << {i_count[1:0], 3'b000});
            o_count  = i_count + 3'd1;
        end
    end
endmodule
